FILE: sv/fct_pkg.sv
package fct_pkg;

	localparam int SLOTS   = 64;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LANES   = (SLOTS < 8) ? SLOTS : 8;
	localparam int CNT_W   = $clog2(SLOTS + LANES + 1);
	localparam int COUNT_W = 32;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 32;

	localparam logic [15:0] GEN_INIT = 16'd1;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_ADD       = 3'd1;
	localparam logic [2:0] OP_SIGNAL    = 3'd2;
	localparam logic [2:0] OP_SIGNAL_ID = 3'd3;
	localparam logic [2:0] OP_DONE      = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_REARM   = 2'd3;

	localparam logic [7:0] NULL_SLOT = 8'hff;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] slot;
	} srch_res_t;

endpackage

FILE: sv/fct_count_ram.sv
module fct_count_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/fct_alloc_search.sv
module fct_alloc_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fct_pkg::SLOT_W-1:0]    qidx,
	output logic                          qbusy,
	output fct_pkg::srch_res_t            res
);

	logic [fct_pkg::SLOTS-1:0]  busy_q;
	logic [fct_pkg::SLOT_W-1:0] hint_q;
	logic [fct_pkg::SLOT_W-1:0] pos_q;
	logic [fct_pkg::CNT_W-1:0]  cnt_q;
	logic                       active_q;
	logic                       done_q;
	logic                       found_q;
	logic [fct_pkg::SLOT_W-1:0] slot_q;

	logic [fct_pkg::SLOT_W-1:0] lane_idx [fct_pkg::LANES];
	logic                       hit;
	logic [fct_pkg::SLOT_W-1:0] hit_idx;
	logic                       last_pass;
	logic [fct_pkg::SLOT_W-1:0] pos_next;
	logic [fct_pkg::SLOT_W-1:0] hint_next;

	assign qbusy = busy_q[qidx];

	// up to LANES consecutive slots probed per cycle, first free one wins
	always_comb begin
		logic [fct_pkg::SLOT_W:0] sum;
		logic [fct_pkg::CNT_W-1:0] probe;
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = 0; j < fct_pkg::LANES; j++) begin
			sum = {1'b0, pos_q} + (fct_pkg::SLOT_W+1)'(j);
			if (sum >= (fct_pkg::SLOT_W+1)'(fct_pkg::SLOTS)) begin
				sum = sum - (fct_pkg::SLOT_W+1)'(fct_pkg::SLOTS);
			end
			lane_idx[j] = sum[fct_pkg::SLOT_W-1:0];
			probe = cnt_q + fct_pkg::CNT_W'(j);
			if (!hit && probe < fct_pkg::CNT_W'(fct_pkg::SLOTS) && !busy_q[lane_idx[j]]) begin
				hit     = 1'b1;
				hit_idx = lane_idx[j];
			end
		end
	end

	always_comb begin
		logic [fct_pkg::SLOT_W:0] p;
		logic [fct_pkg::SLOT_W:0] h;
		last_pass = (cnt_q + fct_pkg::CNT_W'(fct_pkg::LANES)) >= fct_pkg::CNT_W'(fct_pkg::SLOTS);
		p = {1'b0, pos_q} + (fct_pkg::SLOT_W+1)'(fct_pkg::LANES);
		if (p >= (fct_pkg::SLOT_W+1)'(fct_pkg::SLOTS)) begin
			p = p - (fct_pkg::SLOT_W+1)'(fct_pkg::SLOTS);
		end
		pos_next = p[fct_pkg::SLOT_W-1:0];
		h = {1'b0, hit_idx} + (fct_pkg::SLOT_W+1)'(1);
		if (h == (fct_pkg::SLOT_W+1)'(fct_pkg::SLOTS)) begin
			h = '0;
		end
		hint_next = h[fct_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			hint_q   <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			slot_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				pos_q    <= hint_q;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (hit) begin
					busy_q[hit_idx] <= 1'b1;
					hint_q          <= hint_next;
					slot_q          <= hit_idx;
					found_q         <= 1'b1;
					done_q          <= 1'b1;
					active_q        <= 1'b0;
				end else if (last_pass) begin
					found_q  <= 1'b0;
					done_q   <= 1'b1;
					active_q <= 1'b0;
				end else begin
					pos_q <= pos_next;
					cnt_q <= cnt_q + fct_pkg::CNT_W'(fct_pkg::LANES);
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.slot  = slot_q;

endmodule

FILE: sv/completion_fence_table_unit.sv
// Pool of 64 completion-counter slots addressed by (slot, generation) handles. One item is
// worked at a time: add, signal, signal-by-id and done queries read the count memory at
// accept and register their result in the finish state, where a valid add or signal also
// writes the updated count back; the next item is accepted once the result is registered.
// Alloc runs the free-slot search first, which probes 8 slots per cycle round-robin from the
// last hint. A full result register holds the item in its last cycle until the result side
// takes the waiting result.
// Counts live in a single-port-write, registered-read memory that needs no clearing: a slot's
// count is always loaded by alloc before any other item can read it. Generations stay at 1.
// A result may wait in the output register while the next item is accepted.
module completion_fence_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode[2:0], slot_id[10:3], handle_gen[26:11], amount[42:27], zero fill
	input  logic [fct_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], out_slot[9:2], out_gen[25:10], is_done[26], wake[27], zero fill
	output logic [fct_pkg::OUT_W-1:0] m_tdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t                       state_q;
	logic [2:0]                   op_q;
	logic [7:0]                   sid_q;
	logic [15:0]                  gen_q;
	logic [15:0]                  amt_q;
	logic                         m_tvalid_q;
	logic [fct_pkg::OUT_W-1:0]    m_tdata_q;

	logic                         accept;
	logic                         out_free;
	logic                         finish;
	logic                         start;
	fct_pkg::srch_res_t           srch;
	logic [fct_pkg::SLOT_W-1:0]   idx;
	logic [fct_pkg::SLOT_W-1:0]   qidx;
	logic                         slot_busy;
	logic                         in_range;
	logic                         valid_h;
	logic                         valid_id;
	logic [fct_pkg::COUNT_W-1:0]  cnt;
	logic [fct_pkg::COUNT_W-1:0]  amt_x;
	logic [fct_pkg::COUNT_W-1:0]  nv;

	logic                         ram_we;
	logic [fct_pkg::COUNT_W-1:0]  ram_wdata;
	logic [1:0]                   status;
	logic [7:0]                   out_slot;
	logic [15:0]                  out_gen;
	logic                         is_done;
	logic                         wake;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == S_FINISH) && out_free;
	assign start    = accept && (s_tdata[2:0] == fct_pkg::OP_ALLOC);

	assign idx      = sid_q[fct_pkg::SLOT_W-1:0];
	assign qidx     = (op_q == fct_pkg::OP_ALLOC) ? srch.slot : idx;
	assign in_range = !sid_q[7] && (sid_q < 8'(fct_pkg::SLOTS));
	assign valid_id = in_range && slot_busy;
	assign valid_h  = valid_id && (gen_q == fct_pkg::GEN_INIT);
	assign amt_x    = {{(fct_pkg::COUNT_W-16){amt_q[15]}}, amt_q};

	fct_alloc_search u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.qidx  (qidx),
		.qbusy (slot_busy),
		.res   (srch)
	);

	fct_count_ram #(
		.DEPTH(fct_pkg::SLOTS),
		.WIDTH(fct_pkg::COUNT_W)
	) u_count (
		.clk  (clk),
		.we   (ram_we),
		.waddr(qidx),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(s_tdata[3 +: fct_pkg::SLOT_W]),
		.rdata(cnt)
	);

	always_comb begin
		status    = fct_pkg::ST_OK;
		out_slot  = fct_pkg::NULL_SLOT;
		out_gen   = '0;
		is_done   = 1'b0;
		wake      = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = amt_x;
		nv        = cnt + amt_x;
		case (op_q)
			fct_pkg::OP_ALLOC: begin
				if (srch.found) begin
					out_slot = 8'(srch.slot);
					out_gen  = fct_pkg::GEN_INIT;
					ram_we   = finish;
				end else begin
					status = fct_pkg::ST_FULL;
				end
			end
			fct_pkg::OP_ADD: begin
				ram_wdata = nv;
				if (!valid_h) begin
					status = fct_pkg::ST_INVALID;
				end else begin
					ram_we = finish;
					if (nv == '0 || nv[fct_pkg::COUNT_W-1]) begin
						status = fct_pkg::ST_REARM;
					end
				end
			end
			fct_pkg::OP_SIGNAL, fct_pkg::OP_SIGNAL_ID: begin
				ram_wdata = cnt - fct_pkg::COUNT_W'(1);
				if ((op_q == fct_pkg::OP_SIGNAL) ? !valid_h : !valid_id) begin
					status = fct_pkg::ST_INVALID;
				end else begin
					ram_we = finish;
					wake   = (cnt == fct_pkg::COUNT_W'(1));
				end
			end
			fct_pkg::OP_DONE: begin
				if (!valid_h) begin
					status  = fct_pkg::ST_INVALID;
					is_done = 1'b1;
				end else begin
					is_done = (cnt == '0) || cnt[fct_pkg::COUNT_W-1];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			op_q       <= '0;
			sid_q      <= '0;
			gen_q      <= '0;
			amt_q      <= '0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !finish) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= s_tdata[2:0];
						sid_q   <= s_tdata[10:3];
						gen_q   <= s_tdata[26:11];
						amt_q   <= s_tdata[42:27];
						state_q <= start ? S_SEARCH : S_FINISH;
					end
				end
				S_SEARCH: begin
					if (srch.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, wake, is_done, out_gen, out_slot, status};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// counts are only ever written for slots already marked busy
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> slot_busy)
		else $error("count write to a free slot");

	a_search_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch.done |-> state_q == S_SEARCH)
		else $error("search finished outside an alloc");

	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		finish && wake |-> status == fct_pkg::ST_OK && ram_we)
		else $error("wake without a count update");
`endif

endmodule

FILE: tb/fence_table_checker.sv
module fence_table_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	// opcode[2:0], slot_id[10:3], handle_gen[26:11], amount[42:27], zero fill
	input  logic [fct_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], out_slot[9:2], out_gen[25:10], is_done[26], wake[27], zero fill
	input  logic [fct_pkg::OUT_W-1:0] m_tdata,
	output int                        mismatches,
	output int                        pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot;
		logic [15:0] gen;
		logic        done;
		logic        wake;
	} fence_result_t;

	logic          slot_busy [fct_pkg::SLOTS];
	logic [15:0]   slot_gen  [fct_pkg::SLOTS];
	logic [31:0]   slot_cnt  [fct_pkg::SLOTS];
	logic [6:0]    alloc_hint;
	fence_result_t fence_q[$];
	int            miss_n;

	function automatic logic id_ok(input logic [7:0] sid);
		return !sid[7] && (int'(sid) < fct_pkg::SLOTS);
	endfunction

	function automatic logic handle_ok(input logic [7:0] sid, input logic [15:0] hg);
		if (!id_ok(sid))
			return 1'b0;
		return slot_busy[sid] && (slot_gen[sid] == hg);
	endfunction

	function automatic logic drained(input logic [31:0] c);
		return (c == 32'd0) || c[31];
	endfunction

	// advances the slot pool by one item and returns the answer it must give
	function automatic fence_result_t fence_apply(input logic [fct_pkg::IN_W-1:0] d);
		logic [2:0]    op;
		logic [7:0]    sid;
		logic [15:0]   hg;
		logic [31:0]   amt;
		logic [31:0]   prev;
		logic          found;
		logic          ok;
		int            idx;
		fence_result_t r;
		op  = d[2:0];
		sid = d[10:3];
		hg  = d[26:11];
		amt = {{16{d[42]}}, d[42:27]};
		r.status = fct_pkg::ST_OK;
		r.slot   = fct_pkg::NULL_SLOT;
		r.gen    = 16'd0;
		r.done   = 1'b0;
		r.wake   = 1'b0;
		case (op)
			fct_pkg::OP_ALLOC: begin
				found = 1'b0;
				for (int p = 0; p < fct_pkg::SLOTS && !found; p++) begin
					idx = (int'(alloc_hint) + p) % fct_pkg::SLOTS;
					if (!slot_busy[idx]) begin
						found          = 1'b1;
						slot_busy[idx] = 1'b1;
						slot_cnt[idx]  = amt;
						alloc_hint     = 7'(idx + 1);
						r.slot         = 8'(idx);
						r.gen          = slot_gen[idx];
					end
				end
				if (!found)
					r.status = fct_pkg::ST_FULL;
			end
			fct_pkg::OP_ADD: begin
				if (!handle_ok(sid, hg)) begin
					r.status = fct_pkg::ST_INVALID;
				end else begin
					slot_cnt[sid] = slot_cnt[sid] + amt;
					if (drained(slot_cnt[sid]))
						r.status = fct_pkg::ST_REARM;
				end
			end
			fct_pkg::OP_SIGNAL, fct_pkg::OP_SIGNAL_ID: begin
				ok = (op == fct_pkg::OP_SIGNAL) ? handle_ok(sid, hg)
					: (id_ok(sid) && slot_busy[sid]);
				if (!ok) begin
					r.status = fct_pkg::ST_INVALID;
				end else begin
					prev          = slot_cnt[sid];
					slot_cnt[sid] = prev - 32'd1;
					r.wake        = (prev == 32'd1);
				end
			end
			fct_pkg::OP_DONE: begin
				if (!handle_ok(sid, hg)) begin
					r.status = fct_pkg::ST_INVALID;
					r.done   = 1'b1;
				end else begin
					r.done = drained(slot_cnt[sid]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fence_result_t got;
		fence_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < fct_pkg::SLOTS; i++) begin
				slot_busy[i] = 1'b0;
				slot_gen[i]  = fct_pkg::GEN_INIT;
				slot_cnt[i]  = 32'd0;
			end
			alloc_hint = 7'd0;
			fence_q.delete();
			miss_n     = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.slot   = m_tdata[9:2];
				got.gen    = m_tdata[25:10];
				got.done   = m_tdata[26];
				got.wake   = m_tdata[27];
				if (fence_q.size() == 0) begin
					miss_n++;
					if (miss_n <= 10)
						$display("unexpected result item: status %0d slot %0d gen %h done %b wake %b",
							got.status, $signed(got.slot), got.gen, got.done, got.wake);
				end else begin
					want = fence_q.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
						got.gen !== want.gen || got.done !== want.done ||
						got.wake !== want.wake) begin
						miss_n++;
						if (miss_n <= 10) begin
							$write("result mismatch: expected status %0d slot %0d gen %h done %b wake %b,",
								want.status, $signed(want.slot), want.gen, want.done, want.wake);
							$display(" got status %0d slot %0d gen %h done %b wake %b",
								got.status, $signed(got.slot), got.gen, got.done, got.wake);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				fence_q.push_back(fence_apply(s_tdata));
			mismatches <= miss_n;
			pending    <= fence_q.size();
		end
	end

endmodule

FILE: tb/tb_completion_fence_table_unit.sv
module tb_completion_fence_table_unit;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [fct_pkg::IN_W-1:0]  s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [fct_pkg::OUT_W-1:0] m_tdata;
	int                        mismatches;
	int                        pending;
	int                        granted;
	logic                      calm;

	completion_fence_table_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fence_table_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb_completion_fence_table_unit failed");
		$finish;
	end

	// result side: ready in random bursts, always ready once calm
	initial begin
		m_tready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			if (calm) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 30)) @(posedge clk);
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	task automatic push_req(input logic [2:0] op, input logic [7:0] sid,
		input logic [15:0] hg, input logic [15:0] amt);
		logic [fct_pkg::IN_W-1:0] d;
		d        = '0;
		d[2:0]   = op;
		d[10:3]  = sid;
		d[26:11] = hg;
		d[42:27] = amt;
		s_tdata  <= d;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == fct_pkg::OP_ALLOC && granted < fct_pkg::SLOTS)
			granted++;
	endtask

	// hold off until every outstanding item has been answered
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_req();
		int          roll;
		logic [2:0]  op;
		logic [7:0]  sid;
		logic [15:0] hg;
		logic [15:0] amt;
		roll = $urandom_range(0, 99);
		if (roll < 9)
			op = fct_pkg::OP_ALLOC;
		else if (roll < 32)
			op = fct_pkg::OP_ADD;
		else if (roll < 55)
			op = fct_pkg::OP_SIGNAL;
		else if (roll < 70)
			op = fct_pkg::OP_SIGNAL_ID;
		else if (roll < 96)
			op = fct_pkg::OP_DONE;
		else
			op = 3'($urandom_range(5, 7));
		// mostly live handles so counts move through zero and wakes happen
		roll = $urandom_range(0, 19);
		if (granted > 0 && roll < 16)
			sid = 8'($urandom_range(0, granted - 1));
		else if (roll < 18)
			sid = 8'($urandom_range(0, 255));
		else
			sid = 8'($urandom_range(fct_pkg::SLOTS, 127));
		hg = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535)) : fct_pkg::GEN_INIT;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			amt = 16'($urandom_range(0, 5) - 1);
		else if (roll < 9)
			amt = 16'($urandom_range(0, 3) - 3);
		else
			amt = 16'($urandom_range(0, 65535));
		push_req(op, sid, hg, amt);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		calm     = 1'b0;
		granted  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty pool: everything but alloc is an invalid handle
		push_req(fct_pkg::OP_DONE,      8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_SIGNAL_ID, 8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_SIGNAL,    8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_ADD,       8'd0, fct_pkg::GEN_INIT, 16'd5);
		push_req(fct_pkg::OP_ALLOC,     8'd0, 16'd0,    16'd1);
		push_req(fct_pkg::OP_ALLOC,     8'hff, 16'hffff, 16'h8000);
		push_req(fct_pkg::OP_ALLOC,     8'd0, 16'd0,    16'h7fff);
		push_req(fct_pkg::OP_ALLOC,     8'd0, 16'd0,    16'd0);
		push_req(fct_pkg::OP_DONE,      8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_DONE,      8'd0, 16'hffff, 16'd0);
		push_req(fct_pkg::OP_DONE,      8'h80, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_DONE,      8'h7f, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_ADD,       8'd0, fct_pkg::GEN_INIT, 16'h7fff);
		// back down to zero: re-arm
		push_req(fct_pkg::OP_ADD,       8'd0, fct_pkg::GEN_INIT, 16'h8000);
		push_req(fct_pkg::OP_ADD,       8'd0, fct_pkg::GEN_INIT, 16'd1);
		push_req(fct_pkg::OP_SIGNAL,    8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_SIGNAL_ID, 8'd0, 16'habcd, 16'hffff);
		push_req(fct_pkg::OP_DONE,      8'd0, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_ADD,       8'd1, fct_pkg::GEN_INIT, 16'hffff);
		push_req(fct_pkg::OP_ADD,       8'd2, 16'd2,    16'd3);
		push_req(3'd5,                  8'd1, fct_pkg::GEN_INIT, 16'd1);
		push_req(3'd6,                  8'h55, 16'h5555, 16'haaaa);
		push_req(3'd7,                  8'haa, 16'haaaa, 16'h5555);
		push_req(fct_pkg::OP_DONE,      8'd3, fct_pkg::GEN_INIT, 16'd0);
		push_req(fct_pkg::OP_SIGNAL_ID, 8'(fct_pkg::SLOTS), fct_pkg::GEN_INIT, 16'd0);
		settle();

		for (int i = 0; i < 900; i++) begin
			calm = (i >= 800);
			if (i == 450)
				settle();
			if (!calm && (i / 50) % 4 != 3 && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			random_req();
		end

		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_completion_fence_table_unit passed");
		else
			$display("tb_completion_fence_table_unit failed");
		$finish;
	end

endmodule
